// File: hdl/liq_pkg.sv
// Package for the log integral quadrature block: fixed-point constants,
// status codes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package liq_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_STEPS = 1048576;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  // ln(2) in unsigned Q0.32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // Largest magnitude of f, unsigned Q25.32.
  localparam logic [56:0] F_LIMIT = '1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_STEP = 2'd1,
    ST_LIMIT     = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_LOOP = 14'b00000000000010,
    S_PNT  = 14'b00000000000100,
    S_NORM = 14'b00000000001000,
    S_SQR  = 14'b00000000010000,
    S_LNLO = 14'b00000000100000,
    S_LNHI = 14'b00000001000000,
    S_DIV  = 14'b00000010000000,
    S_PDON = 14'b00000100000000,
    S_SCHI = 14'b00001000000000,
    S_SCLO = 14'b00010000000000,
    S_ACC  = 14'b00100000000000,
    S_FIN  = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } state_t;

endpackage

// File: hdl/liq_if.sv
// Request channels of the log integral quadrature block.
// Depends on nothing but the clock domain of the block that uses them.
`timescale 1ns / 1ps

interface liq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] lower_bound;
  logic [31:0] upper_bound;
  logic [31:0] step_width;
  logic        operation;
  modport source (output valid, lower_bound, upper_bound, step_width, operation,
                  input ready);
  modport sink (input valid, lower_bound, upper_bound, step_width, operation,
                output ready);
endinterface

interface liq_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] integral;
  logic [1:0]         status;
  modport source (output valid, integral, status, input ready);
  modport sink (input valid, integral, status, output ready);
endinterface

// File: hdl/log_integral_quadrature.sv
// Top level of the log integral quadrature block: a sequencer around one
// shared 32x32 multiplier. Depends on liq_pkg and the channels in liq_if.
`timescale 1ns / 1ps

// The block integrates f(x) = 1/ln(x) over [lower_bound, upper_bound] in
// slices of step_width, by midpoint rectangles (operation 0) or trapezoids
// (operation 1). One request comes in on in_ch; exactly one result request
// (integral in signed Q32.32 and a status code) leaves on out_ch.
// in_ch.ready is high only while the sequencer is idle, so one request is in
// work at a time. A finished result sits in an output register, and the next
// input request may be taken while that result still waits.
// Each evaluation of f runs a point check, a normalize loop, a squaring loop
// on the multiplier, logarithm steps on the low and high word, the restoring
// divider and a step that collects the value; the points 0 and 1 and a zero
// logarithm skip ahead to that last step. A slice adds a loop check, scaling
// steps on the high and low word and an accumulate step, with one evaluation
// in midpoint mode and two in trapezoid mode, capped at MAX_STEPS slices. A
// zero step goes from idle straight to the final state.
// Reset (synchronous, active low) returns the sequencer to idle and drops a
// pending result. If the receiver stalls, the result is held unchanged and
// a finished computation waits in its final state until the register frees.
module log_integral_quadrature (
  input  logic clk,
  input  logic rst_n,
  liq_in_if.sink    in_ch,
  liq_out_if.source out_ch
);

  liq_pkg::state_t state_r, state_nxt;

  logic [31:0] pos_r, hi_r, h_r, rh_r;
  logic        op_r, second_r;
  logic [63:0] acc_r;
  logic [liq_pkg::CNT_W-1:0] cnt_r;
  logic        sat_r, limit_r, zstep_r;
  logic [32:0] v_r;
  logic [5:0]  k_r;
  logic [31:0] z_r, frac_r;
  logic [5:0]  it_r;
  logic [31:0] lnlo_r;
  logic [37:0] ln_r, rem_r;
  logic [62:0] q_r;
  logic        fneg_r;
  logic [56:0] fmag_r;
  logic signed [57:0] f1_r;
  logic        mneg_r;
  logic [58:0] mmag_r;
  logic [90:0] p_r;
  logic        out_valid_r;
  logic signed [63:0] out_int_r;
  logic [1:0]  out_stat_r;

  // Exponent of log2(v): the top set bit index minus the fraction bits of v.
  logic signed [7:0] e_s;
  logic [7:0]        e_abs;
  logic              e_neg;
  logic [5:0]        lmag_hi;
  logic [31:0]       lmag_lo;

  // Shared multiplier with operands chosen by the sequencer state.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = z_r;
    mul_b = z_r;
    unique case (state_r)
      liq_pkg::S_LNLO: begin
        mul_a = lmag_lo;
        mul_b = liq_pkg::LN2_Q32;
      end
      liq_pkg::S_LNHI: begin
        mul_a = {26'd0, lmag_hi};
        mul_b = liq_pkg::LN2_Q32;
      end
      liq_pkg::S_SCHI: begin
        mul_a = {5'd0, mmag_r[58:32]};
        mul_b = rh_r;
      end
      liq_pkg::S_SCLO: begin
        mul_a = mmag_r[31:0];
        mul_b = rh_r;
      end
      default: begin
        mul_a = z_r;
        mul_b = z_r;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    e_s   = $signed({2'b00, k_r}) - $signed(8'(liq_pkg::FRAC_BITS + 1));
    e_neg = e_s[7];
    e_abs = e_neg ? 8'(-e_s) : 8'(e_s);
    if (!e_neg) begin
      lmag_hi = e_abs[5:0];
      lmag_lo = frac_r;
    end else if (frac_r == 32'd0) begin
      lmag_hi = e_abs[5:0];
      lmag_lo = 32'd0;
    end else begin
      lmag_hi = e_abs[5:0] - 6'd1;
      lmag_lo = 32'(-frac_r);
    end
  end

  // Slice width and first abscissa of the next slice.
  logic [31:0] rem_w, rh_w;
  logic [32:0] v_first;
  always_comb begin
    rem_w   = hi_r - pos_r;
    rh_w    = (rem_w > h_r) ? h_r : rem_w;
    v_first = op_r ? {pos_r, 1'b0} : ({pos_r, 1'b0} + {1'b0, rh_w});
  end

  // One squaring round of the log2 fraction.
  logic [32:0] sq_t;
  assign sq_t = mul_p[63:31];

  // One restoring division step; the dividend is all ones.
  logic [38:0] div_t;
  logic        div_ge;
  assign div_t  = {rem_r, 1'b1};
  assign div_ge = div_t >= {1'b0, ln_r};

  logic [37:0] ln_w;
  assign ln_w = 38'(mul_p) + {6'd0, lnlo_r};

  // Signed sum of the values of f for this slice.
  logic signed [58:0] fs_w, sum_w;
  always_comb begin
    fs_w  = fneg_r ? -$signed({2'b00, fmag_r}) : $signed({2'b00, fmag_r});
    sum_w = op_r ? (fs_w + 59'(f1_r)) : fs_w;
  end

  // Area of the slice and the saturating accumulation.
  logic [90:0] area_full;
  logic        area_sat;
  logic [63:0] area;
  logic [63:0] bias_acc, bias_nxt;
  logic        acc_sat;
  always_comb begin
    area_full = op_r ? (p_r >> (liq_pkg::FRAC_BITS + 1)) : (p_r >> liq_pkg::FRAC_BITS);
    area_sat  = (|area_full[90:64]) || (area_full[63] && (|area_full[62:0]));
    area      = area_sat ? 64'h8000_0000_0000_0000 : area_full[63:0];
    bias_acc  = acc_r ^ 64'h8000_0000_0000_0000;
    acc_sat   = 1'b0;
    if (!mneg_r) begin
      if (area > ~bias_acc) begin
        bias_nxt = '1;
        acc_sat  = 1'b1;
      end else begin
        bias_nxt = bias_acc + area;
      end
    end else begin
      if (area > bias_acc) begin
        bias_nxt = '0;
        acc_sat  = 1'b1;
      end else begin
        bias_nxt = bias_acc - area;
      end
    end
  end

  assign in_ch.ready     = (state_r == liq_pkg::S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.integral = out_int_r;
  assign out_ch.status   = out_stat_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      liq_pkg::S_IDLE: if (in_ch.valid) begin
        state_nxt = (in_ch.step_width == 32'd0) ? liq_pkg::S_FIN : liq_pkg::S_LOOP;
      end
      liq_pkg::S_LOOP: begin
        if (pos_r >= hi_r || cnt_r >= liq_pkg::CNT_W'(liq_pkg::MAX_STEPS)) begin
          state_nxt = liq_pkg::S_FIN;
        end else begin
          state_nxt = liq_pkg::S_PNT;
        end
      end
      liq_pkg::S_PNT: begin
        if (v_r == 33'd0 || v_r == (33'd1 << (liq_pkg::FRAC_BITS + 1))) begin
          state_nxt = liq_pkg::S_PDON;
        end else begin
          state_nxt = liq_pkg::S_NORM;
        end
      end
      liq_pkg::S_NORM: if (v_r[32]) state_nxt = liq_pkg::S_SQR;
      liq_pkg::S_SQR:  if (it_r == 6'd31) state_nxt = liq_pkg::S_LNLO;
      liq_pkg::S_LNLO: state_nxt = liq_pkg::S_LNHI;
      liq_pkg::S_LNHI: state_nxt = (ln_w == 38'd0) ? liq_pkg::S_PDON : liq_pkg::S_DIV;
      liq_pkg::S_DIV:  if (it_r == 6'd63) state_nxt = liq_pkg::S_PDON;
      liq_pkg::S_PDON: state_nxt = (op_r && !second_r) ? liq_pkg::S_PNT : liq_pkg::S_SCHI;
      liq_pkg::S_SCHI: state_nxt = liq_pkg::S_SCLO;
      liq_pkg::S_SCLO: state_nxt = liq_pkg::S_ACC;
      liq_pkg::S_ACC:  state_nxt = liq_pkg::S_LOOP;
      liq_pkg::S_FIN:  if (out_free) state_nxt = liq_pkg::S_IDLE;
      default:         state_nxt = liq_pkg::S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= liq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == liq_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      liq_pkg::S_IDLE: if (in_ch.valid) begin
        op_r    <= in_ch.operation;
        h_r     <= in_ch.step_width;
        acc_r   <= '0;
        cnt_r   <= '0;
        sat_r   <= 1'b0;
        limit_r <= 1'b0;
        zstep_r <= (in_ch.step_width == 32'd0);
        // Midpoint mode integrates reversed bounds in their natural order.
        if (!in_ch.operation && in_ch.lower_bound > in_ch.upper_bound) begin
          pos_r <= in_ch.upper_bound;
          hi_r  <= in_ch.lower_bound;
        end else begin
          pos_r <= in_ch.lower_bound;
          hi_r  <= in_ch.upper_bound;
        end
      end
      liq_pkg::S_LOOP: begin
        rh_r     <= rh_w;
        v_r      <= v_first;
        second_r <= 1'b0;
        k_r      <= 6'd32;
        if (pos_r < hi_r && cnt_r >= liq_pkg::CNT_W'(liq_pkg::MAX_STEPS)) begin
          limit_r <= 1'b1;
        end
      end
      liq_pkg::S_PNT: begin
        fneg_r <= 1'b0;
        fmag_r <= '0;
        k_r    <= 6'd32;
      end
      liq_pkg::S_NORM: begin
        if (v_r[32]) begin
          z_r    <= v_r[32:1];
          frac_r <= '0;
          it_r   <= '0;
        end else begin
          v_r <= {v_r[31:0], 1'b0};
          k_r <= k_r - 6'd1;
        end
      end
      liq_pkg::S_SQR: begin
        z_r    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
        frac_r <= {frac_r[30:0], sq_t[32]};
        it_r   <= it_r + 6'd1;
      end
      liq_pkg::S_LNLO: lnlo_r <= mul_p[63:32];
      liq_pkg::S_LNHI: begin
        ln_r   <= ln_w;
        fneg_r <= e_neg && (ln_w != 38'd0);
        rem_r  <= '0;
        q_r    <= '0;
        it_r   <= '0;
      end
      liq_pkg::S_DIV: begin
        rem_r <= div_ge ? 38'(div_t - {1'b0, ln_r}) : div_t[37:0];
        q_r   <= {q_r[61:0], div_ge};
        it_r  <= it_r + 6'd1;
        if (it_r == 6'd63) begin
          fmag_r <= (|q_r[62:56]) ? liq_pkg::F_LIMIT : {q_r[55:0], div_ge};
        end
      end
      liq_pkg::S_PDON: begin
        if (op_r && !second_r) begin
          f1_r     <= 58'(fs_w);
          second_r <= 1'b1;
          v_r      <= {32'(pos_r + rh_r), 1'b0};
        end else begin
          mneg_r <= sum_w[58];
          mmag_r <= sum_w[58] ? 59'(-sum_w) : 59'(sum_w);
        end
      end
      liq_pkg::S_SCHI: p_r <= {27'd0, mul_p};
      liq_pkg::S_SCLO: p_r <= (p_r << 32) + {27'd0, mul_p};
      liq_pkg::S_ACC: begin
        acc_r <= bias_nxt ^ 64'h8000_0000_0000_0000;
        sat_r <= sat_r || area_sat || acc_sat;
        pos_r <= pos_r + rh_r;
        cnt_r <= cnt_r + liq_pkg::CNT_W'(1);
      end
      liq_pkg::S_FIN: if (out_free) begin
        out_int_r <= $signed(acc_r);
        if (zstep_r) begin
          out_stat_r <= liq_pkg::ST_ZERO_STEP;
        end else if (sat_r) begin
          out_stat_r <= liq_pkg::ST_SATURATED;
        end else if (limit_r) begin
          out_stat_r <= liq_pkg::ST_LIMIT;
        end else begin
          out_stat_r <= liq_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: tb/log_integral_quadrature_tb.sv
// Self-checking testbench of log_integral_quadrature: directed table, then random requests.
// Depends on liq_pkg, the channels in liq_if and the block itself.
`timescale 1ns / 1ps

module log_integral_quadrature_tb;

  localparam int           N_RANDOM   = 80;
  localparam int           IDLE_LIMIT = 40000;
  localparam logic         OP_MID     = 1'b0;
  localparam logic         OP_TRAP    = 1'b1;
  localparam logic [63:0]  SIGN64     = 64'h8000_0000_0000_0000;
  localparam logic [31:0]  ONE_Q      = 32'h0100_0000;

  typedef struct {
    logic [63:0]      integral;
    liq_pkg::status_t status;
  } area_result_t;

  typedef struct {
    logic [31:0]      lower_bound;
    logic [31:0]      upper_bound;
    logic [31:0]      step_width;
    logic             operation;
    bit               typed;
    logic [63:0]      integral;
    liq_pkg::status_t status;
  } quad_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;
  int   idle_cycles = 0;

  area_result_t pending_areas[$];

  liq_in_if  in_ch ();
  liq_out_if out_ch ();

  log_integral_quadrature i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #2 clk = ~clk;

  // 1/ln(v) with v carrying FRAC_BITS+1 fractional bits, as sign and Q32 magnitude.
  function automatic void inv_log(input logic [63:0] v, output bit neg, output logic [63:0] mag);
    int k;
    int e;
    logic [63:0] z;
    logic [63:0] frac;
    logic [63:0] lmag;
    logic [63:0] ln;
    k = -1;
    frac = '0;
    neg = 1'b0;
    mag = '0;
    if (v == 0 || v == (64'd1 << (liq_pkg::FRAC_BITS + 1))) return;
    for (int i = 0; i < 64; i++) if (v[i]) k = i;
    z = (k <= 31) ? (v << (31 - k)) : (v >> (k - 31));
    // Squaring loop: each overflow past 2.0 yields one more fraction bit.
    for (int i = 0; i < 32; i++) begin
      z = (z * z) >> 31;
      if (z >= (64'd1 << 32)) begin
        z = z >> 1;
        frac[31 - i] = 1'b1;
      end
    end
    e = k - (liq_pkg::FRAC_BITS + 1);
    if (e >= 0) begin
      lmag = (64'(e) << 32) + frac;
    end else begin
      lmag = (64'(-e) << 32) - frac;
      neg = 1'b1;
    end
    ln = (lmag >> 32) * 64'(liq_pkg::LN2_Q32)
         + ((64'(lmag[31:0]) * 64'(liq_pkg::LN2_Q32)) >> 32);
    if (ln == 0) begin
      neg = 1'b0;
      return;
    end
    mag = 64'hFFFF_FFFF_FFFF_FFFF / ln;
    if (mag > 64'(liq_pkg::F_LIMIT)) mag = 64'(liq_pkg::F_LIMIT);
  endfunction

  // Slice area magnitude (mag * width) >> shift, clamped at 2^63.
  function automatic logic [63:0] slice_area(input logic [63:0] mag, input logic [31:0] width,
                                             input int shift, inout bit sat);
    logic [63:0] hi_p;
    logic [63:0] lo_p;
    logic [63:0] r;
    logic [63:0] t;
    int s;
    s = 32 - shift;
    hi_p = (mag >> 32) * 64'(width);
    lo_p = 64'(mag[31:0]) * 64'(width);
    if (hi_p > (SIGN64 >> s)) begin
      sat = 1'b1;
      return SIGN64;
    end
    r = hi_p << s;
    t = lo_p >> shift;
    if (t > SIGN64 - r) begin
      sat = 1'b1;
      return SIGN64;
    end
    return r + t;
  endfunction

  function automatic area_result_t integrate(input logic [31:0] lo_in, input logic [31:0] hi_in,
                                             input logic [31:0] h, input logic op);
    area_result_t res;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] pos;
    logic [31:0] rh;
    logic [63:0] biased;
    logic [63:0] m;
    logic [63:0] m1;
    logic [63:0] m2;
    logic signed [63:0] ssum;
    bit sat;
    bit neg;
    bit n1;
    bit n2;
    bit limit;
    int unsigned slices;
    lo = lo_in;
    hi = hi_in;
    sat = 1'b0;
    limit = 1'b0;
    slices = 0;
    biased = SIGN64;
    if (h == 0) begin
      res.integral = '0;
      res.status = liq_pkg::ST_ZERO_STEP;
      return res;
    end
    if (op == OP_MID && lo > hi) begin
      lo = hi_in;
      hi = lo_in;
    end
    pos = lo;
    while (pos < hi) begin
      if (slices >= liq_pkg::MAX_STEPS) begin
        limit = 1'b1;
        break;
      end
      rh = hi - pos;
      if (rh > h) rh = h;
      if (op == OP_MID) begin
        inv_log(2 * 64'(pos) + 64'(rh), neg, m);
        m = slice_area(m, rh, liq_pkg::FRAC_BITS, sat);
      end else begin
        inv_log(2 * 64'(pos), n1, m1);
        inv_log(2 * (64'(pos) + 64'(rh)), n2, m2);
        ssum = (n1 ? -$signed(m1) : $signed(m1)) + (n2 ? -$signed(m2) : $signed(m2));
        neg = ssum < 0;
        m = neg ? 64'(-ssum) : 64'(ssum);
        m = slice_area(m, rh, liq_pkg::FRAC_BITS + 1, sat);
      end
      // The running sum is kept offset-binary so both clamps are plain compares.
      if (!neg) begin
        if (m > ~biased) begin
          biased = '1;
          sat = 1'b1;
        end else begin
          biased = biased + m;
        end
      end else begin
        if (m > biased) begin
          biased = '0;
          sat = 1'b1;
        end else begin
          biased = biased - m;
        end
      end
      pos = pos + rh;
      slices++;
    end
    res.integral = biased ^ SIGN64;
    res.status = sat ? liq_pkg::ST_SATURATED : (limit ? liq_pkg::ST_LIMIT : liq_pkg::ST_OK);
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 80);
  endfunction

  // Directed rows: zero steps, reversed and equal bounds, the point x = 1,
  // field extremes and a single slice across the whole range.
  quad_row_t quad_table[20] = '{
    '{32'h0000_0000, 32'h0200_0000, 32'h0000_0000, OP_MID,  1, 64'd0, liq_pkg::ST_ZERO_STEP},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, OP_TRAP, 1, 64'd0, liq_pkg::ST_ZERO_STEP},
    '{32'h0300_0000, 32'h0200_0000, 32'h0040_0000, OP_TRAP, 1, 64'd0, liq_pkg::ST_OK},
    '{32'h0250_0000, 32'h0250_0000, 32'h0040_0000, OP_TRAP, 1, 64'd0, liq_pkg::ST_OK},
    '{32'h0250_0000, 32'h0250_0000, 32'h0040_0000, OP_MID,  1, 64'd0, liq_pkg::ST_OK},
    '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, OP_TRAP, 1, 64'd0, liq_pkg::ST_OK},
    '{32'h0300_0000, 32'h0200_0000, 32'h0040_0000, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK},
    '{32'h0000_0000, 32'h0000_0001, 32'h0000_0001, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'h0000_0000, 32'h0000_0001, 32'h0000_0001, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK},
    '{ONE_Q,         32'h0180_0000, 32'h0020_0000, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK},
    '{32'h00FF_FFFF, 32'h0100_0001, 32'h0000_0001, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'h00FF_FFFF, 32'h0100_0001, 32'h0000_0001, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK},
    '{32'h0000_0000, 32'h0200_0002, 32'h0200_0002, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'h0080_0000, 32'h0100_0000, 32'h0080_0000, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK},
    '{32'hFF00_0000, 32'hFFFF_FFFF, 32'h0030_0000, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h8000_0000, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK},
    '{32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, OP_MID,  0, 64'd0, liq_pkg::ST_OK},
    '{32'h0100_0000, 32'h0500_0000, 32'h0100_0000, OP_TRAP, 0, 64'd0, liq_pkg::ST_OK}
  };

  // Drives one request from the falling edge and holds it until accepted.
  task automatic send_request(input quad_row_t row);
    area_result_t want;
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    if (gap == 0) @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.lower_bound = row.lower_bound;
    in_ch.upper_bound = row.upper_bound;
    in_ch.step_width  = row.step_width;
    in_ch.operation   = row.operation;
    do @(posedge clk); while (!in_ch.ready);
    if (row.typed) begin
      want.integral = row.integral;
      want.status = row.status;
    end else begin
      want = integrate(row.lower_bound, row.upper_bound, row.step_width, row.operation);
    end
    pending_areas.push_back(want);
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.lower_bound = $urandom();
    in_ch.upper_bound = $urandom();
    in_ch.step_width  = $urandom();
    in_ch.operation   = $urandom_range(0, 1);
  endtask

  // Random request: mostly a few slices of random width, so every item stays
  // short; a few use steps of at least half the range of a field, which cover
  // the interval in at most two slices.
  function automatic quad_row_t random_row();
    quad_row_t row;
    logic [63:0] span;
    int n;
    row.typed = 1'b0;
    row.integral = '0;
    row.status = liq_pkg::ST_OK;
    row.operation = $urandom_range(0, 1);
    row.lower_bound = $urandom();
    if ($urandom_range(0, 2) == 0) row.lower_bound = $urandom_range(0, 32'h0400_0000);
    case ($urandom_range(0, 19)) inside
      0: begin
        row.step_width = 32'd0;
        row.upper_bound = $urandom();
      end
      [1:2]: begin
        row.step_width = $urandom() | 32'h8000_0000;
        row.upper_bound = $urandom();
      end
      default: begin
        row.step_width = $urandom() >> $urandom_range(0, 31);
        if (row.step_width == 0) row.step_width = 32'd1;
        n = $urandom_range(1, 8);
        span = 64'(row.step_width) * n - $urandom_range(0, 1) * (row.step_width >> 1);
        if (span > 64'(32'hFFFF_FFFF - row.lower_bound)) span = 32'hFFFF_FFFF - row.lower_bound;
        row.upper_bound = row.lower_bound + span[31:0];
        if ($urandom_range(0, 5) == 0) begin
          row.upper_bound = row.lower_bound;
          row.lower_bound = row.lower_bound + span[31:0];
        end
      end
    endcase
    return row;
  endfunction

  // Result side: random stalls, with long stretches of ready held high.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if ($urandom_range(0, 1) == 0) begin
        out_ch.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk) begin
    area_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_areas.size() == 0) begin
        $error("unexpected result integral=%h status=%0d", out_ch.integral, out_ch.status);
        failed = 1'b1;
      end else begin
        want = pending_areas.pop_front();
        if (out_ch.integral !== want.integral) begin
          $error("integral expected %h actual %h", want.integral, out_ch.integral);
          failed = 1'b1;
        end
        if (out_ch.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_ch.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.lower_bound = '0;
    in_ch.upper_bound = '0;
    in_ch.step_width = '0;
    in_ch.operation = OP_MID;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (quad_table[i]) send_request(quad_table[i]);
    repeat (N_RANDOM) send_request(random_row());
    while (pending_areas.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/liq_pkg.sv
hdl/liq_if.sv
hdl/log_integral_quadrature.sv
tb/log_integral_quadrature_tb.sv
